@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is active
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

@@ hdl/ppid_pkg.sv @@
// types, register indexes and codes for the parallel pid controller
// no dependencies
`default_nettype none

package ppid_pkg;

  typedef struct packed {
    logic               action;
    logic signed [15:0] setpoint;
    logic signed [15:0] feedback;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic [1:0]         clamp_state;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] kp_gain;
    logic signed [31:0] ki_dt_gain;
    logic signed [31:0] kd_dt_gain;
    logic signed [31:0] total_gain;
    logic [30:0]        i_term_limit;
    logic               d_on_measure;
    logic signed [31:0] out_low;
    logic signed [31:0] out_high;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic accum;
    logic mul_i;
    logic mul_d;
    logic sum;
    logic mul_t;
    logic clamp;
    logic load_out;
  } dp_cmd_t;

  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_HIGH = 2'd1;
  localparam logic [1:0] CLAMP_LOW  = 2'd2;

  localparam logic [2:0] REG_KP       = 3'd0;
  localparam logic [2:0] REG_KI       = 3'd1;
  localparam logic [2:0] REG_KD       = 3'd2;
  localparam logic [2:0] REG_TOTAL    = 3'd3;
  localparam logic [2:0] REG_ILIMIT   = 3'd4;
  localparam logic [2:0] REG_DMEAS    = 3'd5;
  localparam logic [2:0] REG_OUT_LOW  = 3'd6;
  localparam logic [2:0] REG_OUT_HIGH = 3'd7;

  localparam int ADDR_W = 5;

endpackage

`default_nettype wire

@@ hdl/ppid_regs.sv @@
// apb configuration registers of the pid controller
// depends on ppid_pkg
`default_nettype none

module ppid_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ppid_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output ppid_pkg::cfg_t                   cfg_o
);

  ppid_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain      <= 32'sd0;
      cfg_q.ki_dt_gain   <= 32'sd0;
      cfg_q.kd_dt_gain   <= 32'sd0;
      cfg_q.total_gain   <= 32'sd65536;
      cfg_q.i_term_limit <= 31'd0;
      cfg_q.d_on_measure <= 1'b0;
      cfg_q.out_low      <= 32'sh8000_0000;
      cfg_q.out_high     <= 32'sh7fff_ffff;
    end else if (wr_en) begin
      case (idx)
        ppid_pkg::REG_KP:       cfg_q.kp_gain      <= pwdata;
        ppid_pkg::REG_KI:       cfg_q.ki_dt_gain   <= pwdata;
        ppid_pkg::REG_KD:       cfg_q.kd_dt_gain   <= pwdata;
        ppid_pkg::REG_TOTAL:    cfg_q.total_gain   <= pwdata;
        ppid_pkg::REG_ILIMIT:   cfg_q.i_term_limit <= pwdata[30:0];
        ppid_pkg::REG_DMEAS:    cfg_q.d_on_measure <= pwdata[0];
        ppid_pkg::REG_OUT_LOW:  cfg_q.out_low      <= pwdata;
        ppid_pkg::REG_OUT_HIGH: cfg_q.out_high     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ppid_pkg::REG_KP:       prdata = cfg_q.kp_gain;
      ppid_pkg::REG_KI:       prdata = cfg_q.ki_dt_gain;
      ppid_pkg::REG_KD:       prdata = cfg_q.kd_dt_gain;
      ppid_pkg::REG_TOTAL:    prdata = cfg_q.total_gain;
      ppid_pkg::REG_ILIMIT:   prdata = {1'b0, cfg_q.i_term_limit};
      ppid_pkg::REG_DMEAS:    prdata = {31'd0, cfg_q.d_on_measure};
      ppid_pkg::REG_OUT_LOW:  prdata = cfg_q.out_low;
      ppid_pkg::REG_OUT_HIGH: prdata = cfg_q.out_high;
      default:                prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/ppid_ctrl.sv @@
// sequencer for one pid step: issues datapath commands, owns the handshakes
// depends on ppid_pkg
`default_nettype none

module ppid_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_action_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output ppid_pkg::dp_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_MI    = 4'd3;
  localparam logic [3:0] S_MD    = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_MT    = 4'd6;
  localparam logic [3:0] S_CLAMP = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = in_action_i ? S_CLR : S_ACC;
        end
      end
      S_CLR: begin
        cmd_o.clear = 1'b1;
        state_d = S_DONE;
      end
      S_ACC: begin
        cmd_o.accum = 1'b1;
        state_d = S_MI;
      end
      S_MI: begin
        cmd_o.mul_i = 1'b1;
        state_d = S_MD;
      end
      S_MD: begin
        cmd_o.mul_d = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d = S_MT;
      end
      S_MT: begin
        cmd_o.mul_t = 1'b1;
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ppid_dp.sv @@
// pid datapath: one shared multiplier, term registers, integrator and history
// depends on ppid_pkg
`default_nettype none

module ppid_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ppid_pkg::dp_cmd_t      cmd_i,
  input  wire ppid_pkg::cfg_t         cfg_i,
  input  wire ppid_pkg::in_beat_t     in_data_i,
  output ppid_pkg::out_beat_t         out_data_o
);

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [39:0] S40_MAX = 40'sh7f_ffff_ffff;
  localparam logic signed [39:0] S40_MIN = 40'sh80_0000_0000;
  localparam logic signed [32:0] S33_MAX = 33'sh0_ffff_ffff;
  localparam logic signed [32:0] S33_MIN = 33'sh1_0000_0000;

  function automatic logic signed [31:0] sat_prod(input logic signed [64:0] v);
    logic fits;
    fits = (v[64:31] == '0) || (v[64:31] == '1);
    if (fits) begin
      return v[31:0];
    end
    return v[64] ? S32_MIN : S32_MAX;
  endfunction

  // payload registers
  logic signed [15:0] fb_q;
  logic signed [16:0] err_q;
  logic signed [64:0] prod_q;
  logic signed [31:0] p_q, i_q, sum_q;
  ppid_pkg::out_beat_t res_q, out_q;

  // controller state kept across beats
  logic signed [39:0] es_q, es_prev_q;
  logic signed [16:0] last_err_q;
  logic signed [15:0] last_fb_q;

  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [64:0] mul_p;
  logic signed [40:0] es_add;
  logic signed [39:0] es_next;
  logic signed [32:0] es_short;
  logic signed [17:0] diff;
  logic signed [31:0] i_raw, i_lim, d_term;
  logic signed [32:0] i_wide, lim_wide;
  logic signed [33:0] pid_add;
  logic signed [31:0] pid_sat;
  logic signed [48:0] raw;
  logic signed [31:0] drive;
  logic [1:0]         clamp_st;
  logic               undo;

  assign es_add  = {es_q[39], es_q} + {{24{err_q[16]}}, err_q};
  assign es_next = (es_add > $signed({S40_MAX[39], S40_MAX})) ? S40_MAX :
                   (es_add < $signed({S40_MIN[39], S40_MIN})) ? S40_MIN : es_add[39:0];

  // any integrator beyond 33 bits saturates the i product for nonzero gain
  assign es_short = (es_q > $signed({{7{S33_MAX[32]}}, S33_MAX})) ? S33_MAX :
                    (es_q < $signed({{7{S33_MIN[32]}}, S33_MIN})) ? S33_MIN : es_q[32:0];

  assign diff = cfg_i.d_on_measure ?
                ({{2{last_fb_q[15]}}, last_fb_q} - {{2{fb_q[15]}}, fb_q}) :
                ({err_q[16], err_q} - {last_err_q[16], last_err_q});

  always_comb begin
    mul_a = cfg_i.total_gain;
    mul_b = {sum_q[31], sum_q};
    if (cmd_i.accum) begin
      mul_a = cfg_i.kp_gain;
      mul_b = {{16{err_q[16]}}, err_q};
    end else if (cmd_i.mul_i) begin
      mul_a = cfg_i.ki_dt_gain;
      mul_b = es_short;
    end else if (cmd_i.mul_d) begin
      mul_a = cfg_i.kd_dt_gain;
      mul_b = {{15{diff[17]}}, diff};
    end
  end

  assign mul_p = {{33{mul_a[31]}}, mul_a} * {{32{mul_b[32]}}, mul_b};

  // integral term clamp, zero limit disables it
  assign i_raw    = sat_prod(prod_q);
  assign i_wide   = {i_raw[31], i_raw};
  assign lim_wide = {2'b00, cfg_i.i_term_limit};
  always_comb begin
    i_lim = i_raw;
    if (cfg_i.i_term_limit != 31'd0) begin
      if (i_wide > lim_wide) begin
        i_lim = lim_wide[31:0];
      end else if (i_wide < -lim_wide) begin
        i_lim = -lim_wide[31:0];
      end
    end
  end

  assign d_term  = sat_prod(prod_q);
  assign pid_add = {{2{p_q[31]}}, p_q} + {{2{i_q[31]}}, i_q} + {{2{d_term[31]}}, d_term};
  assign pid_sat = (pid_add[33:31] == 3'b000 || pid_add[33:31] == 3'b111) ? pid_add[31:0] :
                   (pid_add[33] ? S32_MIN : S32_MAX);

  // floor shift of the total product, then the output clamp, upper first
  assign raw = prod_q[64:16];
  always_comb begin
    drive    = raw[31:0];
    clamp_st = ppid_pkg::CLAMP_NONE;
    if (raw > $signed({{17{cfg_i.out_high[31]}}, cfg_i.out_high})) begin
      drive    = cfg_i.out_high;
      clamp_st = ppid_pkg::CLAMP_HIGH;
    end else if (raw < $signed({{17{cfg_i.out_low[31]}}, cfg_i.out_low})) begin
      drive    = cfg_i.out_low;
      clamp_st = ppid_pkg::CLAMP_LOW;
    end
  end

  assign undo = (cfg_i.ki_dt_gain != 32'sd0) &&
                (((clamp_st == ppid_pkg::CLAMP_HIGH) && !err_q[16] && (err_q != 17'sd0)) ||
                 ((clamp_st == ppid_pkg::CLAMP_LOW) && err_q[16]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      fb_q  <= in_data_i.feedback;
      err_q <= {in_data_i.setpoint[15], in_data_i.setpoint}
             - {in_data_i.feedback[15], in_data_i.feedback};
    end
    if (cmd_i.accum || cmd_i.mul_i || cmd_i.mul_d || cmd_i.mul_t) begin
      prod_q <= mul_p;
    end
    if (cmd_i.mul_i) begin
      p_q <= sat_prod(prod_q);
    end
    if (cmd_i.mul_d) begin
      i_q <= i_lim;
    end
    if (cmd_i.sum) begin
      sum_q <= pid_sat;
    end
    if (cmd_i.clamp) begin
      res_q.drive       <= drive;
      res_q.clamp_state <= clamp_st;
    end else if (cmd_i.clear) begin
      res_q <= '0;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      es_q       <= '0;
      es_prev_q  <= '0;
      last_err_q <= '0;
      last_fb_q  <= '0;
    end else if (cmd_i.clear) begin
      es_q       <= '0;
      es_prev_q  <= '0;
      last_err_q <= '0;
      last_fb_q  <= '0;
    end else begin
      if (cmd_i.accum) begin
        es_prev_q <= es_q;
        es_q      <= es_next;
      end
      if (cmd_i.sum) begin
        last_err_q <= err_q;
        last_fb_q  <= fb_q;
      end
      if (cmd_i.clamp && undo) begin
        es_q <= es_prev_q;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

@@ hdl/parallel_pid_controller_core.sv @@
// parallel pid controller top: apb registers, sequencer and shared-multiplier datapath
// a compute beat runs through four passes of one 32x33 multiplier; the result is valid once
// the done state loads it into a free output register, and only then is the next beat accepted
// a clear beat skips the passes; the output register lets a new beat start while one waits
// rst_ni clears registers to their reset values and the integrator and history to zero
`default_nettype none

module parallel_pid_controller_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire ppid_pkg::in_beat_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output ppid_pkg::out_beat_t              out_data_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ppid_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  ppid_pkg::cfg_t    cfg;
  ppid_pkg::dp_cmd_t cmd;

  ppid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ppid_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

@@ hdl/ppid_checker.sv @@
// port-level checks for the pid controller top, attached by bind
// depends on ppid_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ppid_port_assert (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire ppid_pkg::out_beat_t out_data_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i
);

  // output beat holds while stalled
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))

  // one beat in flight: no accept on the cycle after an accept
  `ASSERT_CLK(a_one_at_a_time, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)

  // clamp code is never the unused value
  `ASSERT_CLK(a_clamp_code, clk_i, rst_ni, out_valid_o |-> (out_data_o.clamp_state != 2'd3))

  // nothing presented right after reset is seen asserted
  `ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind parallel_pid_controller_core ppid_port_assert u_ppid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);

`default_nettype wire
